FILE: sv/sbpa_pkg.sv
package sbpa_pkg;

  localparam int REG_POOLS      = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_SIZE_BASE  = 0;
  localparam int CFG_COUNT_BASE = 4;

  localparam int SIZE_W  = 16;
  localparam int COUNT_W = 5;
  localparam int POOL_W  = 2;
  localparam int BLK_W   = 4;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  localparam int RESET_SIZE0 = 16;
  localparam int RESET_COUNT = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic load_in;
    logic exec_free;
    logic exec_fail;
    logic issue_read;
    logic exec_pop;
    logic clr_start;
    logic clr_step;
  } sbpa_cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic is_free;
    logic alloc_hit;
    logic clr_last;
  } sbpa_sts_t;

endpackage

FILE: sv/sbpa_ctrl.sv
module sbpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  sbpa_pkg::sbpa_sts_t sts,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output sbpa_pkg::sbpa_cmd_t cmd
);
  import sbpa_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   load_out;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && !sts.cfg_wr;
  assign out_tvalid = out_valid_r;
  assign load_out   = cmd.exec_free || cmd.exec_fail || cmd.exec_pop;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    if (sts.cfg_wr) begin
      cmd.clr_start = 1'b1;
      state_nxt     = ST_CLEAR;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          cmd.clr_step = 1'b1;
          if (sts.clr_last) begin
            state_nxt = ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd.load_in = 1'b1;
            state_nxt   = ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (sts.is_free) begin
            if (slot_free) begin
              cmd.exec_free = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end else if (sts.alloc_hit) begin
            cmd.issue_read = 1'b1;
            state_nxt      = ST_POP;
          end else if (slot_free) begin
            cmd.exec_fail = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
        ST_POP: begin
          if (slot_free) begin
            cmd.exec_pop = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
        default: state_nxt = ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/sbpa_dpath.sv
module sbpa_dpath #(
  parameter int NUM_POOLS       = 4,
  parameter int BLOCKS_PER_POOL = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sbpa_pkg::sbpa_cmd_t              cmd,
  output sbpa_pkg::sbpa_sts_t              sts,
  input  logic                             cfg_wr,
  input  logic [sbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_opcode,
  input  logic [sbpa_pkg::SIZE_W-1:0]      in_request_size,
  input  logic [sbpa_pkg::POOL_W-1:0]      in_free_pool,
  input  logic [sbpa_pkg::BLK_W-1:0]       in_free_block,
  output logic                             out_status,
  output logic [sbpa_pkg::POOL_W-1:0]      out_granted_pool,
  output logic [sbpa_pkg::BLK_W-1:0]       out_granted_block
);
  import sbpa_pkg::*;

  localparam int DEPTH = NUM_POOLS * BLOCKS_PER_POOL;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(BLOCKS_PER_POOL + 1);
  localparam int BW    = $clog2(BLOCKS_PER_POOL);
  localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int EW    = (HW > COUNT_W) ? HW : COUNT_W;
  localparam logic [HW-1:0] MARK = HW'(BLOCKS_PER_POOL);

  logic [SIZE_W-1:0]  size_r  [NUM_POOLS];
  logic [COUNT_W-1:0] count_r [NUM_POOLS];
  logic [HW-1:0]      head_r  [NUM_POOLS];
  logic [HW-1:0]      mem     [DEPTH];
  logic [HW-1:0]      rdata_r;

  logic               opcode_r;
  logic [SIZE_W-1:0]  req_r;
  logic [POOL_W-1:0]  fpool_r;
  logic [BLK_W-1:0]   fblock_r;

  logic               status_r;
  logic [POOL_W-1:0]  gpool_r;
  logic [BLK_W-1:0]   gblock_r;

  logic [PW-1:0]      clr_pool_r, clr_pool_nxt;
  logic [BW-1:0]      clr_blk_r, clr_blk_nxt;

  logic [NUM_POOLS-1:0] in_use;
  logic [EW-1:0]        eff [NUM_POOLS];
  logic                 found;
  logic [PW-1:0]        sel;
  logic [HW-1:0]        head_sel;
  logic                 free_use;
  logic [PW-1:0]        free_sel;
  logic [HW-1:0]        head_free;
  logic [EW-1:0]        eff_free;
  logic                 free_ok;
  logic                 clr_use;
  logic [EW-1:0]        eff_clr;
  logic                 clr_last;

  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [HW-1:0]        mem_wd;
  logic [AW-1:0]        mem_ra;

  function automatic logic [AW-1:0] addr_of(logic [PW-1:0] p, logic [HW-1:0] b);
    logic [AW:0] t;
    t = (AW+1)'(p) * (AW+1)'(BLOCKS_PER_POOL) + (AW+1)'(b);
    return t[AW-1:0];
  endfunction

  always_comb begin
    logic run;
    run = 1'b1;
    for (int p = 0; p < NUM_POOLS; p++) begin
      run       = run && (size_r[p] != '0);
      in_use[p] = run;
      eff[p]    = (EW'(count_r[p]) > EW'(BLOCKS_PER_POOL)) ?
                  EW'(BLOCKS_PER_POOL) : EW'(count_r[p]);
    end
  end

  always_comb begin
    found    = 1'b0;
    sel      = '0;
    head_sel = MARK;
    for (int p = NUM_POOLS - 1; p >= 0; p--) begin
      if (in_use[p] && (size_r[p] >= req_r)) begin
        found = 1'b1;
        sel   = PW'(p);
      end
    end
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (found && (sel == PW'(p))) begin
        head_sel = head_r[p];
      end
    end
  end

  always_comb begin
    free_use  = 1'b0;
    free_sel  = '0;
    head_free = MARK;
    eff_free  = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (int'(fpool_r) == p) begin
        free_use  = in_use[p];
        free_sel  = PW'(p);
        head_free = head_r[p];
        eff_free  = eff[p];
      end
    end
    free_ok = free_use && (EW'(fblock_r) < eff_free);
  end

  always_comb begin
    clr_use = 1'b0;
    eff_clr = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (clr_pool_r == PW'(p)) begin
        clr_use = in_use[p];
        eff_clr = eff[p];
      end
    end
    clr_last = (clr_pool_r == PW'(NUM_POOLS - 1)) &&
               (clr_blk_r == BW'(BLOCKS_PER_POOL - 1));
  end

  assign sts.cfg_wr    = cfg_wr;
  assign sts.is_free   = (opcode_r == OP_FREE);
  assign sts.alloc_hit = found && (head_sel != MARK);
  assign sts.clr_last  = clr_last;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_of(clr_pool_r, HW'(clr_blk_r));
    mem_wd = MARK;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      if (clr_use && ((EW'(clr_blk_r) + EW'(1)) < eff_clr)) begin
        mem_wd = HW'(EW'(clr_blk_r) + EW'(1));
      end
    end else if (cmd.exec_free && free_ok) begin
      mem_we = 1'b1;
      mem_wa = addr_of(free_sel, HW'(fblock_r));
      mem_wd = head_free;
    end
  end

  assign mem_ra = addr_of(sel, head_sel);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.issue_read) begin
      rdata_r <= mem[mem_ra];
    end
  end

  always_comb begin
    clr_pool_nxt = clr_pool_r;
    clr_blk_nxt  = clr_blk_r;
    if (cmd.clr_start) begin
      clr_pool_nxt = '0;
      clr_blk_nxt  = '0;
    end else if (cmd.clr_step && !clr_last) begin
      if (clr_blk_r == BW'(BLOCKS_PER_POOL - 1)) begin
        clr_blk_nxt  = '0;
        clr_pool_nxt = clr_pool_r + PW'(1);
      end else begin
        clr_blk_nxt = clr_blk_r + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_pool_r <= '0;
      clr_blk_r  <= '0;
    end else begin
      clr_pool_r <= clr_pool_nxt;
      clr_blk_r  <= clr_blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        size_r[p]  <= (p < REG_POOLS) ? SIZE_W'(RESET_SIZE0 << p) : '0;
        count_r[p] <= COUNT_W'(RESET_COUNT);
      end
    end else if (cfg_wr) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        if (p < REG_POOLS) begin
          if (int'(cfg_index) == CFG_SIZE_BASE + p) begin
            size_r[p] <= cfg_data[SIZE_W-1:0];
          end
          if (int'(cfg_index) == CFG_COUNT_BASE + p) begin
            count_r[p] <= cfg_data[COUNT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (cmd.clr_step) begin
        head_r[p] <= (in_use[p] && (eff[p] != '0)) ? '0 : MARK;
      end else if (cmd.exec_free && free_ok && (free_sel == PW'(p))) begin
        head_r[p] <= HW'(fblock_r);
      end else if (cmd.exec_pop && (sel == PW'(p))) begin
        head_r[p] <= rdata_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      opcode_r <= in_opcode;
      req_r    <= in_request_size;
      fpool_r  <= in_free_pool;
      fblock_r <= in_free_block;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_free) begin
      status_r <= free_ok ? STATUS_OK : STATUS_FAIL;
      gpool_r  <= '0;
      gblock_r <= '0;
    end else if (cmd.exec_fail) begin
      status_r <= STATUS_FAIL;
      gpool_r  <= '0;
      gblock_r <= '0;
    end else if (cmd.exec_pop) begin
      status_r <= STATUS_OK;
      gpool_r  <= POOL_W'(sel);
      gblock_r <= BLK_W'(head_sel);
    end
  end

  assign out_status        = status_r;
  assign out_granted_pool  = gpool_r;
  assign out_granted_block = gblock_r;

endmodule

FILE: sv/size_class_block_pool_allocator.sv
// Channel | Direction | Handshake            | Payload
// in_     | in        | in_tvalid/in_tready  | tuser: opcode; tdata: request_size, free_pool,
//         |           |                      |        free_block
// out_    | out       | out_tvalid/out_tready| tuser: status; tdata: granted_pool, granted_block
// cfg_    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A free or failed allocate goes through EXEC before the next acceptance, a successful
// allocate through EXEC and POP, for the registered read of the free-list link memory.
// Reset and every configuration write start a rebuild pass over all
// NUM_POOLS*BLOCKS_PER_POOL link memory entries; no request is accepted during it.
// A result is held in the output register; a request in flight waits until it drains.
module size_class_block_pool_allocator #(
  parameter int NUM_POOLS       = 4,
  parameter int BLOCKS_PER_POOL = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sbpa_pkg::IN_DATA_W-1:0]    in_tdata,  // request_size, free_pool, free_block
  input  logic                              in_tuser,  // opcode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sbpa_pkg::OUT_DATA_W-1:0]   out_tdata, // granted_pool, granted_block
  output logic                              out_tuser, // status
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbpa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sbpa_pkg::*;

  sbpa_cmd_t         cmd;
  sbpa_sts_t         sts;
  logic              cfg_wr;
  logic [POOL_W-1:0] granted_pool;
  logic [BLK_W-1:0]  granted_block;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  sbpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sbpa_dpath #(
    .NUM_POOLS       (NUM_POOLS),
    .BLOCKS_PER_POOL (BLOCKS_PER_POOL)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr            (cfg_wr),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_opcode         (in_tuser),
    .in_request_size   (in_tdata[15:0]),
    .in_free_pool      (in_tdata[17:16]),
    .in_free_block     (in_tdata[21:18]),
    .out_status        (out_tuser),
    .out_granted_pool  (granted_pool),
    .out_granted_block (granted_block)
  );

  assign out_tdata = {2'b00, granted_block, granted_pool};

  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_free || cmd.exec_fail || cmd.exec_pop) |-> (!out_tvalid || out_tready))
    else $error("result loaded over an untaken result");

  a_cfg_rebuild : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_tready)
    else $error("request accepted during rebuild pass");

  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STATUS_FAIL)) |-> (out_tdata == '0))
    else $error("failed result carries a grant");

endmodule
